FILE: hw/rtl/edd_pkg.sv
package edd_pkg;

  // fixed field widths
  localparam int LEVEL_W  = 8;
  localparam int CFG_W    = 12;
  localparam int NUM_CHAN = 3;

  // defaults for the top level parameters
  localparam int LINE_MAX_DEF  = 2048;
  localparam int FRAC_BITS_DEF = 4;

  // line_length after reset
  localparam logic [CFG_W-1:0] LEN_RESET = 12'd2048;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // diffusion weights, in sixteenths
  localparam int WEIGHT_RIGHT       = 7;
  localparam int WEIGHT_BELOW_LEFT  = 3;
  localparam int WEIGHT_BELOW       = 5;
  localparam int WEIGHT_BELOW_RIGHT = 1;
  localparam int WEIGHT_SHIFT       = 4;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } edd_pix_t;

  // per-pixel classification made by the front
  typedef struct packed {
    logic frame_start;
    logic first_line;
    logic last;
  } edd_ctl_t;

endpackage

FILE: hw/rtl/edd_if.sv
interface edd_in_if import edd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  logic               frame_start;

  modport source (output valid, red_level, green_level, blue_level, frame_start,
                  input ready);
  modport sink   (input valid, red_level, green_level, blue_level, frame_start,
                  output ready);
endinterface

interface edd_out_if;
  logic valid;
  logic ready;
  logic red_bit;
  logic green_bit;
  logic blue_bit;
  logic end_of_line;

  modport source (output valid, red_bit, green_bit, blue_bit, end_of_line,
                  input ready);
  modport sink   (input valid, red_bit, green_bit, blue_bit, end_of_line,
                  output ready);
endinterface

interface edd_cfg_if import edd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] line_length;

  modport source (output valid, line_length, input ready);
  modport sink   (input valid, line_length, output ready);
endinterface

FILE: hw/rtl/edd_front.sv
module edd_front import edd_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  edd_cfg_if.sink                     cfg_wr,
  edd_in_if.sink                      in_px,
  input  logic                        q_ready,
  output logic                        push,
  output logic [$clog2(LINE_MAX)-1:0] push_x,
  output edd_pix_t                    push_pix,
  output edd_ctl_t                    push_ctl
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  logic [CFG_W-1:0] len_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic             first_r, first_nxt;
  logic [LW-1:0]    len_ext, len_eff;
  logic [CW-1:0]    x;
  logic             last;

  // line length register, always ready
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_wr.valid) begin
      len_r <= cfg_wr.line_length;
    end
  end

  // clamp the length to 1..LINE_MAX
  always_comb begin
    len_ext = LW'(len_r);
    if (len_ext == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > LW'(LINE_MAX)) begin
      len_eff = LW'(LINE_MAX);
    end else begin
      len_eff = len_ext;
    end
  end

  // classify the incoming word
  always_comb begin
    x    = in_px.frame_start ? '0 : col_r;
    last = (LW'(x) + LW'(1)) >= len_eff;
  end

  assign in_px.ready = q_ready;
  assign push        = in_px.valid & q_ready;
  assign push_x      = x;
  assign push_pix    = '{red: in_px.red_level, green: in_px.green_level,
                         blue: in_px.blue_level};
  assign push_ctl    = '{frame_start: in_px.frame_start,
                         first_line:  in_px.frame_start | first_r,
                         last:        last};

  // column and first-line tracking
  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    if (push) begin
      col_nxt   = last ? '0 : x + CW'(1);
      first_nxt = last ? 1'b0 : (in_px.frame_start | first_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

FILE: hw/rtl/edd_queue.sv
module edd_queue import edd_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign ready = count_r != CNTW'(QUEUE_DEPTH);
  assign valid = count_r != '0;
  assign dout  = slots_r[rd_ptr_r];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNTW'(1);
      2'b01:   count_nxt = count_r - CNTW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/edd_back.sv
module edd_back import edd_pkg::*; #(
  parameter int LINE_MAX      = LINE_MAX_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  logic [$clog2(LINE_MAX)-1:0] q_x,
  input  edd_pix_t                    q_pix,
  input  edd_ctl_t                    q_ctl,
  output logic                        q_pop,
  edd_out_if.source                   out_px
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int EW = 10 + FRACTION_BITS;
  localparam int VW = EW + 2;
  localparam int MW = NUM_CHAN * EW;
  localparam int PW = EW + 3;

  localparam logic signed [VW-1:0] SAT_HI = VW'(2 ** (EW - 1) - 1);
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [VW-1:0] FULL   = VW'(255 << FRACTION_BITS);
  localparam logic signed [VW-1:0] HALF   = VW'(255 << (FRACTION_BITS - 1));

  // saturate to the error range
  function automatic logic signed [EW-1:0] sat_e(input logic signed [VW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[EW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[EW-1:0];
    end else begin
      r = v[EW-1:0];
    end
    return r;
  endfunction

  // floor(weight * e / 16)
  function automatic logic signed [EW-1:0] share(input logic signed [EW-1:0] e,
                                                  input int w);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] s;
    p = PW'(e) * $signed(PW'(w));
    s = p >>> WEIGHT_SHIFT;
    return s[EW-1:0];
  endfunction

  // stage B: pixel waiting for its line store data
  logic            b_valid_r, b_valid_nxt;
  logic [CW-1:0]   b_x;
  edd_pix_t        b_pix;
  edd_ctl_t        b_ctl;
  logic            b_fire;

  // line store and forwarding
  logic [MW-1:0]   mem_r [LINE_MAX];
  logic [MW-1:0]   mem_q_r;
  logic [MW-1:0]   fwd_r, fwd_nxt;
  logic            use_fwd_r, use_fwd_nxt;
  logic            wr_en;
  logic [CW-1:0]   wr_addr;
  logic [MW-1:0]   wr_data;
  logic            st_we;
  logic [CW-1:0]   st_addr;
  logic [MW-1:0]   st_data;

  // right-hand column entry held outside the store
  logic [MW-1:0]   tail_r;
  logic [CW-1:0]   tail_col_r;
  logic            tail_valid_r, tail_valid_nxt;
  logic [MW-1:0]   tail_data;

  // per-channel state
  logic signed [EW-1:0] carry_r [NUM_CHAN];
  logic signed [EW-1:0] pend_r  [NUM_CHAN];
  logic signed [EW-1:0] diag_r  [NUM_CHAN];
  logic signed [EW-1:0] carry_nxt [NUM_CHAN];
  logic signed [EW-1:0] pend_nxt  [NUM_CHAN];
  logic signed [EW-1:0] diag_nxt  [NUM_CHAN];

  logic [LEVEL_W-1:0]   lvl   [NUM_CHAN];
  logic signed [EW-1:0] cin   [NUM_CHAN];
  logic signed [EW-1:0] pin   [NUM_CHAN];
  logic signed [EW-1:0] din   [NUM_CHAN];
  logic signed [EW-1:0] below [NUM_CHAN];
  logic signed [VW-1:0] value [NUM_CHAN];
  logic signed [EW-1:0] err   [NUM_CHAN];
  logic signed [EW-1:0] s7    [NUM_CHAN];
  logic signed [EW-1:0] s3    [NUM_CHAN];
  logic signed [EW-1:0] s5    [NUM_CHAN];
  logic signed [EW-1:0] s1    [NUM_CHAN];
  logic signed [EW-1:0] down  [NUM_CHAN];
  logic [NUM_CHAN-1:0]  bits;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic red_r, green_r, blue_r, eol_r;

  // handshakes
  assign b_fire = b_valid_r & (~out_valid_r | out_px.ready);
  assign q_pop  = q_valid & (~b_valid_r | b_fire);

  always_comb begin
    b_valid_nxt   = q_pop | (b_valid_r & ~b_fire);
    out_valid_nxt = b_fire | (out_valid_r & ~out_px.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_x       <= q_x;
      b_pix     <= q_pix;
      b_ctl     <= q_ctl;
      fwd_r     <= fwd_nxt;
      use_fwd_r <= use_fwd_nxt;
    end
  end

  // per-channel diffusion
  always_comb begin
    lvl[0] = b_pix.red;
    lvl[1] = b_pix.green;
    lvl[2] = b_pix.blue;
    for (int c = 0; c < NUM_CHAN; c++) begin
      cin[c] = b_ctl.frame_start ? '0 : carry_r[c];
      pin[c] = b_ctl.frame_start ? '0 : pend_r[c];
      din[c] = b_ctl.frame_start ? '0 : diag_r[c];
      if (b_ctl.first_line) begin
        below[c] = '0;
      end else if (use_fwd_r) begin
        below[c] = fwd_r[c*EW +: EW];
      end else begin
        below[c] = mem_q_r[c*EW +: EW];
      end
      value[c] = $signed(VW'({lvl[c], {FRACTION_BITS{1'b0}}})) + VW'(cin[c])
                 + VW'(below[c]);
      bits[c]  = value[c] > HALF;
      err[c]   = sat_e(bits[c] ? value[c] - FULL : value[c]);
      s7[c]    = share(err[c], WEIGHT_RIGHT);
      s3[c]    = share(err[c], WEIGHT_BELOW_LEFT);
      s5[c]    = share(err[c], WEIGHT_BELOW);
      s1[c]    = share(err[c], WEIGHT_BELOW_RIGHT);
      down[c]  = sat_e(VW'(din[c]) + VW'(s5[c]));
      wr_data[c*EW +: EW]   = sat_e(VW'(pin[c]) + VW'(s3[c]));
      tail_data[c*EW +: EW] = down[c];
      carry_nxt[c] = carry_r[c];
      pend_nxt[c]  = pend_r[c];
      diag_nxt[c]  = diag_r[c];
      if (b_fire) begin
        if (b_ctl.last) begin
          carry_nxt[c] = '0;
          pend_nxt[c]  = '0;
          diag_nxt[c]  = '0;
        end else begin
          carry_nxt[c] = s7[c];
          pend_nxt[c]  = down[c];
          diag_nxt[c]  = s1[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        carry_r[c] <= '0;
        pend_r[c]  <= '0;
        diag_r[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        carry_r[c] <= carry_nxt[c];
        pend_r[c]  <= pend_nxt[c];
        diag_r[c]  <= diag_nxt[c];
      end
    end
  end

  // line store: write below-left, read at the popped column
  assign wr_en   = b_fire & (b_x != '0);
  assign wr_addr = b_x - CW'(1);

  // a free write slot moves the tail entry into the store
  assign st_we   = wr_en | tail_valid_r;
  assign st_addr = wr_en ? wr_addr : tail_col_r;
  assign st_data = wr_en ? wr_data : tail_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      mem_r[st_addr] <= st_data;
    end
    if (q_pop) begin
      mem_q_r <= mem_r[q_x];
    end
  end

  // forwarding of writes that the store read cannot yet see
  always_comb begin
    use_fwd_nxt = 1'b1;
    if (b_fire && b_ctl.last && (b_x == q_x)) begin
      fwd_nxt = tail_data;
    end else if (wr_en && (wr_addr == q_x)) begin
      fwd_nxt = wr_data;
    end else if (tail_valid_r && (tail_col_r == q_x)) begin
      fwd_nxt = tail_r;
    end else begin
      fwd_nxt     = tail_r;
      use_fwd_nxt = 1'b0;
    end
  end

  // tail entry: set at line end, dropped once it is in the store or overwritten
  always_comb begin
    tail_valid_nxt = tail_valid_r;
    if (b_fire && b_ctl.last) begin
      tail_valid_nxt = 1'b1;
    end else if (!wr_en || (wr_addr == tail_col_r)) begin
      tail_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_valid_r <= 1'b0;
    end else begin
      tail_valid_r <= tail_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_ctl.last) begin
      tail_r     <= tail_data;
      tail_col_r <= b_x;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (b_fire) begin
      red_r   <= bits[0];
      green_r <= bits[1];
      blue_r  <= bits[2];
      eol_r   <= b_ctl.last;
    end
  end

  assign out_px.valid       = out_valid_r;
  assign out_px.red_bit     = red_r;
  assign out_px.green_bit   = green_r;
  assign out_px.blue_bit    = blue_r;
  assign out_px.end_of_line = eol_r;

  // a frame start always lands on the left column
  assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_ctl.frame_start |-> b_x == '0)
    else $error("frame start word not at column zero");

  // a frame start always counts as first line
  assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_ctl.frame_start |-> b_ctl.first_line)
    else $error("frame start word not marked first line");

  // the line end leaves its entry in the tail register
  assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_ctl.last |=> tail_valid_r && (tail_col_r == $past(b_x)))
    else $error("tail entry lost at line end");

  // the word after a line end starts a new line
  assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_ctl.last |=> !b_valid_r || (b_x == '0))
    else $error("line did not restart at column zero");

endmodule

FILE: hw/rtl/error_diffusion_dither.sv
// Channel   Dir  Handshake            Word
// cfg_wr    in   valid/ready (ready=1) line_length
// in_px     in   valid/ready          red/green/blue level, frame_start
// out_px    out  valid/ready          red/green/blue bit, end_of_line
//
// One pixel a cycle sustained while out_px is ready; results pass the queue, stage B and the output register.
// The per-channel error carry to the next pixel is held in the carry register.
// rst_n is synchronous: line length 2048, column 0, first line, errors zero.
// The line store holds no reset; the first line of a frame ignores it.
// A two-word queue and the output register let input and output stall apart.
module error_diffusion_dither import edd_pkg::*; #(
  parameter int LINE_MAX      = LINE_MAX_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  edd_cfg_if.sink   cfg_wr,
  edd_in_if.sink    in_px,
  edd_out_if.source out_px
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int QW = CW + $bits(edd_pix_t) + $bits(edd_ctl_t);

  logic          f_push;
  logic [CW-1:0] f_x;
  edd_pix_t      f_pix;
  edd_ctl_t      f_ctl;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_in, q_head;
  logic [CW-1:0] h_x;
  edd_pix_t      h_pix;
  edd_ctl_t      h_ctl;

  // classify words and track the column
  edd_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_px    (in_px),
    .q_ready  (q_ready),
    .push     (f_push),
    .push_x   (f_x),
    .push_pix (f_pix),
    .push_ctl (f_ctl)
  );

  assign q_in = {f_x, f_pix, f_ctl};

  // queue between front and back
  edd_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (q_in),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  assign {h_x, h_pix, h_ctl} = q_head;

  // error diffusion and line store
  edd_back #(
    .LINE_MAX      (LINE_MAX),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_x     (h_x),
    .q_pix   (h_pix),
    .q_ctl   (h_ctl),
    .q_pop   (q_pop),
    .out_px  (out_px)
  );

endmodule
